@@ rtl/assert_macros.svh @@
// Assertion macros shared by the matcher RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define WNM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that an expression is never true outside reset.
`define WNM_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ rtl/wnm_pkg.sv @@
// Shared types, codes and helpers of the wildcard name matcher.
// No dependencies.
package wnm_pkg;

  localparam logic       OP_MASK_WRITE = 1'b0;
  localparam logic       OP_NAME_FEED  = 1'b1;

  localparam logic [7:0] WILD_ONE      = 8'h3F;
  localparam logic [7:0] WILD_MANY     = 8'h2A;
  localparam logic [7:0] CHAR_END      = 8'h00;

  // Matching state apart from the mask position.
  typedef struct packed {
    logic skip;
    logic done;
    logic match;
  } match_state_t;

  // Fold ASCII lower case letters to upper case.
  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

@@ rtl/wnm_mask_ram.sv @@
// Mask byte store: one write port, two registered read ports.
// Depends on nothing; instantiated by wildcard_name_matcher.
module wnm_mask_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [7:0]    rd_data_a,
  output logic [7:0]    rd_data_b
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

@@ rtl/wnm_match_core.sv @@
// Match state and per-byte decision logic of the wildcard name matcher.
// Depends on wnm_pkg; mask bytes come from wnm_mask_ram.
module wnm_match_core import wnm_pkg::*; #(
  parameter int MASK_DEPTH = 256,
  parameter int PW         = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          issue_first,
  output logic [PW-1:0] rd_addr_a,
  output logic [PW-1:0] rd_addr_b,
  input  logic          commit,
  input  logic          step_feed,
  input  logic          step_first,
  input  logic [7:0]    step_char,
  input  logic [7:0]    m0,
  input  logic [7:0]    m1,
  output match_state_t  st,
  output match_state_t  st_next
);

  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
    return (p == PW'(MASK_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // Mask bytes at the position and the one after it.
  assign rd_addr_a = issue_first ? '0 : pos;
  assign rd_addr_b = adv(rd_addr_a);

  always_comb begin
    logic [PW-1:0] p;
    logic [PW-1:0] p1;
    match_state_t  s;
    p  = step_first ? '0 : pos;
    s  = step_first ? '0 : st;
    p1 = adv(p);
    pos_next = p;
    st_next  = s;
    if (!step_feed) begin
      pos_next = pos;
      st_next  = st;
    end else if (!s.done) begin
      if (s.skip) begin
        if (step_char == m0) begin
          st_next.skip = 1'b0;
          if (step_char == CHAR_END) begin
            st_next.done  = 1'b1;
            st_next.match = 1'b1;
          end else begin
            pos_next = p1;
          end
        end else if (step_char == CHAR_END) begin
          st_next.skip  = 1'b0;
          st_next.done  = 1'b1;
          st_next.match = 1'b0;
        end
      end else if (m0 == CHAR_END && step_char == CHAR_END) begin
        st_next.done  = 1'b1;
        st_next.match = 1'b1;
      end else if (m0 == WILD_ONE) begin
        if (step_char == CHAR_END) begin
          st_next.done  = 1'b1;
          st_next.match = 1'b0;
        end else begin
          pos_next = p1;
        end
      end else if (m0 == step_char) begin
        pos_next = p1;
      end else if (m0 == WILD_MANY) begin
        // Step over the star and look at the byte behind it.
        pos_next = p1;
        if (step_char == m1) begin
          if (step_char == CHAR_END) begin
            st_next.done  = 1'b1;
            st_next.match = 1'b1;
          end else begin
            pos_next = adv(p1);
          end
        end else if (step_char == CHAR_END) begin
          st_next.done  = 1'b1;
          st_next.match = 1'b0;
        end else begin
          st_next.skip = 1'b1;
        end
      end else begin
        st_next.done  = 1'b1;
        st_next.match = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      st  <= '0;
    end else if (commit) begin
      pos <= pos_next;
      st  <= st_next;
    end
  end

endmodule

@@ rtl/wildcard_name_matcher.sv @@
// Top level of the wildcard name matcher: handshakes, decision stage, result register.
// Depends on wnm_pkg, wnm_mask_ram, wnm_match_core and assert_macros.svh.
//
//   channel   signals                                          direction
//   request   req_valid/req_stall, opcode, mask_index,         in
//             char_in, first_of_name
//   result    res_valid/res_stall, verdict_ready, matched      out
//
// A request runs in order: the accept edge issues the mask reads at the current
// position and the one after it; the decision edge, once the result register is
// free, takes the decision and loads the result register. As one name byte needs
// the position left by the one before, req_stall holds until the decision fires.
// rst (synchronous) clears the match state and both valid flags; the mask store
// is not cleared and holds garbage until written.
// A stalled result holds in its register while the next request is still taken.
`include "assert_macros.svh"

module wildcard_name_matcher import wnm_pkg::*; #(
  parameter int MASK_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       opcode,
  input  logic [7:0] mask_index,
  input  logic [7:0] char_in,
  input  logic       first_of_name,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       verdict_ready,
  output logic       matched
);

  localparam int PW = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;

  // Decision stage holding one request.
  logic         busy;
  logic         b_op;
  logic         b_first;
  logic [7:0]   b_char;

  logic         accept;
  logic         step_fire;
  logic         out_free;
  logic [31:0]  idx_ext;
  logic         wr_en;
  logic [7:0]   folded;

  logic [PW-1:0] rd_addr_a;
  logic [PW-1:0] rd_addr_b;
  logic [7:0]    m0;
  logic [7:0]    m1;
  match_state_t  st;
  match_state_t  st_next;

  assign req_stall = busy;
  assign accept    = req_valid && !busy;
  assign out_free  = !res_valid || !res_stall;
  assign step_fire = busy && out_free;
  assign folded    = fold_upper(char_in);

  // Drop mask writes beyond the end of the store.
  assign idx_ext = 32'(mask_index);
  assign wr_en   = accept && (opcode == OP_MASK_WRITE) && (idx_ext < 32'(MASK_DEPTH));

  wnm_mask_ram #(
    .DEPTH (MASK_DEPTH),
    .AW    (PW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (idx_ext[PW-1:0]),
    .wr_data   (folded),
    .rd_en     (accept && (opcode == OP_NAME_FEED)),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (m0),
    .rd_data_b (m1)
  );

  wnm_match_core #(
    .MASK_DEPTH (MASK_DEPTH),
    .PW         (PW)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .issue_first (first_of_name),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .commit      (step_fire),
    .step_feed   (b_op == OP_NAME_FEED),
    .step_first  (b_first),
    .step_char   (b_char),
    .m0          (m0),
    .m1          (m1),
    .st          (st),
    .st_next     (st_next)
  );

  // Hold the request in the decision stage until the result register frees up.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (step_fire) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_op    <= opcode;
      b_first <= first_of_name;
      b_char  <= folded;
    end
  end

  // Advance the result register when the decision fires; drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step_fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      verdict_ready <= st_next.done;
      matched       <= st_next.done && st_next.match;
    end
  end

  `WNM_ASSERT(a_fire_gives_result, step_fire |=> res_valid, "decision fired but no result")
  `WNM_NEVER(a_skip_after_verdict, st.skip && st.done, "skipping after verdict")
  `WNM_ASSERT(a_match_needs_ready, res_valid && matched |-> verdict_ready, "match without verdict")
  `WNM_ASSERT(a_verdict_sticky,
              step_fire && b_op == OP_NAME_FEED && !b_first && st.done
              |=> verdict_ready && matched == $past(st.match), "verdict changed mid-name")

endmodule
